>>> hw/rtl/tlba_pkg.sv
// ----------------------------------------------------------------------------
// tlba_pkg
// Shared types, codes and helpers of the two-level bitmap block allocator.
// ----------------------------------------------------------------------------
package tlba_pkg;

   localparam int          DEF_WORD_BITS    = 32;
   localparam int          MAX_WORD_BITS    = 64;
   localparam int          INDEX_W          = 10;
   localparam int          COUNT_W          = 11;
   localparam logic [10:0] RESET_NUM_BLOCKS = 11'd1024;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_QUERY = 2'd2
   } tlba_mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } tlba_status_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_EXEC
   } tlba_state_type;

   // position of the highest set bit, 0 when none is set
   function automatic logic [5:0] hi_bit(input logic [MAX_WORD_BITS-1:0] v);
      logic [5:0] pos;
      pos = 6'd0;
      for (int i = 0; i < MAX_WORD_BITS; i++) begin
         if (v[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

endpackage

>>> hw/rtl/tlba_map_ram.sv
// ----------------------------------------------------------------------------
// tlba_map_ram
// Map word storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tlba_map_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/two_level_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// two_level_bitmap_block_allocator
// Fixed-block allocator over a two-level free bitmap: a summary register over the words of one map memory.
// ----------------------------------------------------------------------------
// An item is accepted in ST_IDLE: the block index is split into a word index
// (a reciprocal multiply), or the highest non-empty word is picked from the
// summary. ST_DIV then takes the bit index and reads the map memory, and
// ST_EXEC writes any changed word back and registers the response; it
// waits while a registered response is stalled. Items are handled one at a
// time, so a new item is accepted only after the last one leaves ST_EXEC; the
// next item is taken while the last response still waits in the output
// register. After reset and after every num_blocks write the map memory is
// swept, one word per cycle, and req_stall stays high during that sweep.
module two_level_bitmap_block_allocator #(
   parameter int WORD_BITS = tlba_pkg::DEF_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_num_blocks,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [9:0]  req_block_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_result_index,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_allocated,
   output logic [10:0] rsp_free_count,
   output logic        rsp_all_free,
   output logic        rsp_none_free
);

   import tlba_pkg::*;

   localparam int          WIDX        = $clog2(WORD_BITS);
   localparam logic [12:0] CAPACITY    = 13'(WORD_BITS * WORD_BITS);
   localparam logic [12:0] RESET_N13   = (CAPACITY < 13'(RESET_NUM_BLOCKS)) ?
                                         CAPACITY : 13'(RESET_NUM_BLOCKS);
   localparam int          RECIP_SHIFT = INDEX_W + WIDX;
   localparam int          RECIP       = ((2 ** RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int          PROD_W      = INDEX_W + RECIP_SHIFT + 1;
   localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORD_BITS - 1);

   function automatic logic [10:0] eff_count(input logic [10:0] v);
      if ({2'b00, v} > CAPACITY) begin
         return CAPACITY[10:0];
      end
      return v;
   endfunction

   tlba_state_type       state_ff, state_in;
   tlba_mode_type        mode_ff, mode_in;
   logic [9:0]           idx_ff, idx_in;
   logic [9:0]           q_ff, q_in;
   logic [WIDX-1:0]      b_ff, b_in;
   logic                 miss_ff, miss_in;
   logic [WORD_BITS-1:0] summary_ff, summary_in;
   logic [10:0]          free_ff, free_in;
   logic [10:0]          n_ff, n_in;
   logic [WIDX-1:0]      init_w_ff, init_w_in;
   logic [12:0]          base_ff, base_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [9:0]           rsp_result_index_ff, rsp_result_index_in;
   tlba_status_type      rsp_status_ff, rsp_status_in;
   logic                 rsp_is_allocated_ff, rsp_is_allocated_in;
   logic [10:0]          rsp_free_count_ff, rsp_free_count_in;
   logic                 rsp_all_free_ff, rsp_all_free_in;
   logic                 rsp_none_free_ff, rsp_none_free_in;

   logic                 mem_wr_en;
   logic [WIDX-1:0]      mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic [WORD_BITS-1:0] rd_data;

   logic [12:0]          init_rem;
   logic                 init_live;
   logic [WORD_BITS-1:0] init_mask;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    prod_sh;
   logic [5:0]           sum_top;
   logic [5:0]           rd_top;
   logic [WIDX-1:0]      rd_top_w;
   logic [15:0]          diff16;
   logic [15:0]          alloc_index16;
   logic                 bit_set;
   logic [WORD_BITS-1:0] alloc_word;
   logic [WORD_BITS-1:0] free_word;
   logic                 proceed;

   tlba_map_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_BITS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (q_ff[WIDX-1:0]),
      .rd_data (rd_data)
   );

   assign init_rem  = {2'b00, n_ff} - base_ff;
   assign init_live = base_ff < {2'b00, n_ff};

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         init_mask[b] = init_live && ((init_rem >= 13'(WORD_BITS)) || (13'(b) < init_rem));
      end
   end

   assign prod          = PROD_W'(req_block_index) * PROD_W'(RECIP);
   assign prod_sh       = prod >> RECIP_SHIFT;
   assign sum_top       = hi_bit(MAX_WORD_BITS'(summary_ff));
   assign rd_top        = hi_bit(MAX_WORD_BITS'(rd_data));
   assign rd_top_w      = rd_top[WIDX-1:0];
   assign diff16        = 16'(idx_ff) - 16'(q_ff) * 16'(WORD_BITS);
   assign alloc_index16 = 16'(q_ff) * 16'(WORD_BITS) + 16'(rd_top_w);
   assign bit_set       = rd_data[b_ff];
   assign alloc_word    = rd_data & ~(WORD_BITS'(1) << rd_top_w);
   assign free_word     = rd_data | (WORD_BITS'(1) << b_ff);
   assign proceed       = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_w_ff    <= '0;
         base_ff      <= '0;
         n_ff         <= RESET_N13[10:0];
         free_ff      <= RESET_N13[10:0];
         summary_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_w_ff    <= init_w_in;
         base_ff      <= base_in;
         n_ff         <= n_in;
         free_ff      <= free_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff             <= mode_in;
      idx_ff              <= idx_in;
      q_ff                <= q_in;
      b_ff                <= b_in;
      miss_ff             <= miss_in;
      rsp_result_index_ff <= rsp_result_index_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_is_allocated_ff <= rsp_is_allocated_in;
      rsp_free_count_ff   <= rsp_free_count_in;
      rsp_all_free_ff     <= rsp_all_free_in;
      rsp_none_free_ff    <= rsp_none_free_in;
   end

   always_comb begin
      state_in            = state_ff;
      mode_in             = mode_ff;
      idx_in              = idx_ff;
      q_in                = q_ff;
      b_in                = b_ff;
      miss_in             = miss_ff;
      summary_in          = summary_ff;
      free_in             = free_ff;
      n_in                = n_ff;
      init_w_in           = init_w_ff;
      base_in             = base_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_result_index_in = rsp_result_index_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_is_allocated_in = rsp_is_allocated_ff;
      rsp_free_count_in   = rsp_free_count_ff;
      rsp_all_free_in     = rsp_all_free_ff;
      rsp_none_free_in    = rsp_none_free_ff;
      mem_wr_en           = 1'b0;
      mem_wr_addr         = q_ff[WIDX-1:0];
      mem_wr_data         = rd_data;
      req_stall           = (state_ff != ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            mem_wr_en             = 1'b1;
            mem_wr_addr           = init_w_ff;
            mem_wr_data           = init_mask;
            summary_in[init_w_ff] = init_live;
            init_w_in             = init_w_ff + WIDX'(1);
            base_in               = base_ff + 13'(WORD_BITS);
            if (init_w_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = tlba_mode_type'(req_mode);
               idx_in  = req_block_index;
               q_in    = prod_sh[9:0];
               miss_in = 1'b0;
               case (tlba_mode_type'(req_mode))
                  MODE_ALLOC: begin
                     miss_in = (summary_ff == '0);
                     q_in    = 10'(sum_top[WIDX-1:0]);
                  end
                  MODE_FREE, MODE_QUERY: begin
                     miss_in = (11'(req_block_index) >= n_ff);
                  end
                  default: begin
                     miss_in = 1'b0;
                  end
               endcase
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            b_in     = diff16[WIDX-1:0];
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (proceed) begin
               rsp_result_index_in = '0;
               rsp_status_in       = STATUS_OK;
               rsp_is_allocated_in = 1'b0;
               case (mode_ff)
                  MODE_ALLOC: begin
                     if (miss_ff) begin
                        rsp_status_in = STATUS_NO_FREE;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = alloc_word;
                        if (alloc_word == '0) begin
                           summary_in[q_ff[WIDX-1:0]] = 1'b0;
                        end
                        free_in             = free_ff - 11'd1;
                        rsp_result_index_in = alloc_index16[9:0];
                     end
                  end
                  MODE_FREE: begin
                     if (miss_ff || bit_set) begin
                        rsp_status_in = STATUS_BAD_INDEX;
                     end else begin
                        mem_wr_en                  = 1'b1;
                        mem_wr_data                = free_word;
                        summary_in[q_ff[WIDX-1:0]] = 1'b1;
                        free_in                    = free_ff + 11'd1;
                     end
                  end
                  MODE_QUERY: begin
                     if (miss_ff) begin
                        rsp_status_in = STATUS_BAD_INDEX;
                     end else begin
                        rsp_is_allocated_in = !bit_set;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_OK;
                  end
               endcase
               rsp_free_count_in = free_in;
               rsp_all_free_in   = (free_in == n_ff);
               rsp_none_free_in  = (free_in == '0);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (csr_wr_en) begin
         n_in      = eff_count(csr_num_blocks);
         free_in   = eff_count(csr_num_blocks);
         init_w_in = '0;
         base_in   = '0;
         state_in  = ST_INIT;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_result_index_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_allocated = rsp_is_allocated_ff;
   assign rsp_free_count   = rsp_free_count_ff;
   assign rsp_all_free     = rsp_all_free_ff;
   assign rsp_none_free    = rsp_none_free_ff;

endmodule

>>> hw/rtl/tlba_checker.sv
// ----------------------------------------------------------------------------
// tlba_checker
// Port-level checks on the allocator's responses, bound to the top level.
// ----------------------------------------------------------------------------
module tlba_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_result_index,
   input logic [1:0]  rsp_status,
   input logic        rsp_is_allocated,
   input logic [10:0] rsp_free_count,
   input logic        rsp_all_free,
   input logic        rsp_none_free
);

   import tlba_pkg::*;

   // a no-free status always comes with the none_free flag and a zero count
   a_no_free_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NO_FREE) |-> (rsp_none_free && rsp_free_count == '0))
      else $error("no-free status without an empty pool");

   // a rejected index gives no block and no query answer
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_BAD_INDEX) |->
      (rsp_result_index == '0 && !rsp_is_allocated))
      else $error("bad index item carries a payload");

   // none_free tracks the count
   a_none_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_none_free == (rsp_free_count == '0)))
      else $error("none_free disagrees with free_count");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_free_count) && $stable(rsp_result_index) &&
       $stable(rsp_status) && $stable(rsp_is_allocated) &&
       $stable(rsp_all_free) && $stable(rsp_none_free)))
      else $error("stalled item changed");

endmodule

bind two_level_bitmap_block_allocator tlba_checker u_tlba_checker (.*);

>>> verif/two_level_bitmap_block_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_bitmap_block_allocator_checker
// Watches the request, response and register ports of the allocator, keeps
// its own copy of the free bitmaps and counters, predicts the response of
// every accepted item and compares it as a whole, in arrival order.
// ----------------------------------------------------------------------------
module two_level_bitmap_block_allocator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_num_blocks,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [9:0]  req_block_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_result_index,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_is_allocated,
   input  logic [10:0] rsp_free_count,
   input  logic        rsp_all_free,
   input  logic        rsp_none_free,
   output int          mismatch_count,
   output int          pending_count
);

   import tlba_pkg::*;

   localparam int MAP_WORDS = DEF_WORD_BITS;
   localparam int CAPACITY  = MAP_WORDS * MAP_WORDS;

   typedef struct packed {
      logic [9:0]  result_index;
      logic [1:0]  status;
      logic        is_allocated;
      logic [10:0] free_count;
      logic        all_free;
      logic        none_free;
   } alloc_rsp_type;

   logic [MAP_WORDS-1:0] free_map [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_has_free;
   logic [10:0]          free_total;
   logic [10:0]          managed;
   alloc_rsp_type        expected_q [$];
   int                   errors = 0;

   function automatic int top_bit(input logic [MAP_WORDS-1:0] v);
      for (int i = MAP_WORDS - 1; i >= 0; i--) begin
         if (v[i]) begin
            return i;
         end
      end
      return 0;
   endfunction

   function automatic void rebuild_maps(input logic [10:0] count);
      managed = (count > 11'(CAPACITY)) ? 11'(CAPACITY) : count;
      word_has_free = '0;
      for (int w = 0; w < MAP_WORDS; w++) begin
         free_map[w] = '0;
      end
      for (int i = 0; i < int'(managed); i++) begin
         free_map[i / MAP_WORDS][i % MAP_WORDS] = 1'b1;
         word_has_free[i / MAP_WORDS] = 1'b1;
      end
      free_total = managed;
   endfunction

   function automatic alloc_rsp_type step_allocator(input logic [1:0] mode,
                                                    input logic [9:0] idx);
      alloc_rsp_type r;
      int            w;
      int            b;
      r = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_ALLOC: begin
            if (free_total == 0 || word_has_free == '0) begin
               r.status = STATUS_NO_FREE;
            end else begin
               w = top_bit(word_has_free);
               b = top_bit(free_map[w]);
               free_map[w][b] = 1'b0;
               if (free_map[w] == '0) begin
                  word_has_free[w] = 1'b0;
               end
               free_total = free_total - 11'd1;
               r.result_index = 10'(w * MAP_WORDS + b);
            end
         end
         MODE_FREE, MODE_QUERY: begin
            if (11'(idx) >= managed) begin
               r.status = STATUS_BAD_INDEX;
            end else begin
               w = int'(idx) / MAP_WORDS;
               b = int'(idx) % MAP_WORDS;
               if (mode == MODE_QUERY) begin
                  r.is_allocated = !free_map[w][b];
               end else if (free_map[w][b]) begin
                  r.status = STATUS_BAD_INDEX;
               end else begin
                  free_map[w][b] = 1'b1;
                  word_has_free[w] = 1'b1;
                  free_total = free_total + 11'd1;
               end
            end
         end
         default: begin
         end
      endcase
      r.free_count = free_total;
      r.all_free   = (free_total == managed);
      r.none_free  = (free_total == 0);
      return r;
   endfunction

   function automatic string show(input alloc_rsp_type r);
      return $sformatf("idx=%0d status=%0d alloc=%0b free=%0d all=%0b none=%0b",
                       r.result_index, r.status, r.is_allocated, r.free_count,
                       r.all_free, r.none_free);
   endfunction

   always @(posedge clock) begin : monitor
      alloc_rsp_type seen;
      alloc_rsp_type want;
      if (reset) begin
         rebuild_maps(RESET_NUM_BLOCKS);
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_result_index, rsp_status, rsp_is_allocated, rsp_free_count,
                    rsp_all_free, rsp_none_free};
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t checker: item with nothing expected: %s", $realtime,
                           show(seen));
               end
            end else begin
               want = expected_q.pop_front();
               if (seen !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t checker: mismatch expected %s", $realtime, show(want));
                     $display("%0t checker:          actual   %s", $realtime, show(seen));
                  end
               end
            end
         end
         if (csr_wr_en) begin
            rebuild_maps(csr_num_blocks);
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(step_allocator(req_mode, req_block_index));
         end
      end
      pending_count  <= expected_q.size();
      mismatch_count <= errors;
   end

endmodule

>>> verif/two_level_bitmap_block_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_bitmap_block_allocator_test
// Drives directed and random allocate, free and query items through the
// allocator under several block counts, with random idling on both sides,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module two_level_bitmap_block_allocator_test;
   import tlba_pkg::*;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS   = 650;
   localparam int         CALM_ITEMS     = 80;
   localparam int         LONG_HOLD      = 90;
   localparam int         SETTLE         = 8;
   localparam int         WATCHDOG_LIMIT = 2000;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        csr_wr_en       = 1'b0;
   logic [10:0] csr_num_blocks  = 11'd0;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode        = MODE_ALLOC;
   logic [9:0]  req_block_index = 10'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [9:0]  rsp_result_index;
   logic [1:0]  rsp_status;
   logic        rsp_is_allocated;
   logic [10:0] rsp_free_count;
   logic        rsp_all_free;
   logic        rsp_none_free;

   int mismatch_count;
   int pending_count;
   int quiet_cycles  = 0;
   bit tx_idle_en    = 1'b0;
   bit rsp_idle_en   = 1'b0;
   bit long_hold_req = 1'b0;
   int managed       = 1024;
   int allocs_issued = 0;
   int alloc_pct     = 45;

   two_level_bitmap_block_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_num_blocks   (csr_num_blocks),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status),
      .rsp_is_allocated (rsp_is_allocated),
      .rsp_free_count   (rsp_free_count),
      .rsp_all_free     (rsp_all_free),
      .rsp_none_free    (rsp_none_free)
   );

   two_level_bitmap_block_allocator_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_num_blocks   (csr_num_blocks),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status),
      .rsp_is_allocated (rsp_is_allocated),
      .rsp_free_count   (rsp_free_count),
      .rsp_all_free     (rsp_all_free),
      .rsp_none_free    (rsp_none_free),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // response side: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_req = 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("two_level_bitmap_block_allocator_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [9:0] idx);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_block_index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_block_count(input logic [10:0] count);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_num_blocks <= count;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      managed        = (count > 11'd1024) ? 1024 : int'(count);
      allocs_issued  = 0;
   endtask

   // frees and queries aim mostly at the high blocks, which go out first
   task automatic random_item();
      int         roll;
      int         span;
      logic [9:0] idx;
      roll = $urandom_range(0, 99);
      if (managed == 0) begin
         idx = 10'($urandom);
      end else begin
         span = (allocs_issued + 2 < managed - 1) ? allocs_issued + 2 : managed - 1;
         idx  = 10'(managed - 1 - $urandom_range(0, span));
      end
      if (roll < 6) begin
         send_item(2'($urandom_range(0, 3)), 10'($urandom));
      end else if (roll < 6 + alloc_pct) begin
         send_item(MODE_ALLOC, 10'($urandom));
         allocs_issued++;
      end else if (roll < 85) begin
         send_item(MODE_FREE, idx);
      end else if (roll < 95) begin
         send_item(MODE_QUERY, idx);
      end else begin
         send_item(MODE_QUERY, 10'($urandom));
      end
   endtask

   function automatic logic [10:0] pick_count(input int phase);
      case (phase)
         0:       return 11'd1;
         1:       return 11'd2047;
         2:       return 11'd24;
         3:       return 11'd0;
         4:       return 11'd1024;
         5:       return 11'd1023;
         default: begin
            if ($urandom_range(0, 4) == 0) begin
               return 11'($urandom_range(100, 2047));
            end
            return 11'($urandom_range(1, 70));
         end
      endcase
   endfunction

   initial begin
      int sent;
      int phase;
      int len;
      bit calm;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: full pool after reset
      send_item(MODE_ALLOC, 10'd0);
      send_item(MODE_QUERY, 10'd1023);
      send_item(MODE_QUERY, 10'd0);
      send_item(MODE_FREE, 10'd1023);
      send_item(MODE_FREE, 10'd1023);
      send_item(MODE_UNUSED, 10'h3FF);
      // tiny pool: out of range, exhaustion, frees
      set_block_count(11'd5);
      send_item(MODE_FREE, 10'd5);
      send_item(MODE_QUERY, 10'd1023);
      repeat (6) send_item(MODE_ALLOC, 10'h2AA);
      send_item(MODE_QUERY, 10'd4);
      send_item(MODE_FREE, 10'd0);
      send_item(MODE_FREE, 10'd4);
      // no blocks managed
      set_block_count(11'd0);
      send_item(MODE_ALLOC, 10'd0);
      send_item(MODE_QUERY, 10'd0);
      send_item(MODE_FREE, 10'd0);
      // count saturates at capacity
      set_block_count(11'd2047);
      send_item(MODE_ALLOC, 10'd0);
      send_item(MODE_QUERY, 10'h3FF);
      set_block_count(11'd1);
      send_item(MODE_ALLOC, 10'd0);
      send_item(MODE_ALLOC, 10'd0);
      send_item(MODE_FREE, 10'd0);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
         set_block_count(pick_count(phase));
         alloc_pct   = $urandom_range(30, 60);
         tx_idle_en  = !calm && phase != 2 && $urandom_range(0, 3) != 0;
         rsp_idle_en = !calm && $urandom_range(0, 3) != 0;
         if (phase == 2) begin
            long_hold_req = 1'b1;
         end
         len = $urandom_range(30, 70);
         for (int k = 0; k < len; k++) begin
            random_item();
            sent++;
            if (phase == 4 && k == len / 2) begin
               req_valid <= 1'b0;
               wait_drained();
            end else if (tx_idle_en && $urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 18)) @(posedge clock);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("two_level_bitmap_block_allocator_test: clean");
      end else begin
         $display("two_level_bitmap_block_allocator_test: errors");
      end
      $finish;
   end

endmodule
